// ===== design/lrm_pkg.sv =====
package lrm_pkg;

    // width of the register index on the configuration port
    localparam int CFG_INDEX_WIDTH = 8;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_INPUT_LOW      = cfg_index_t'(0);
    localparam cfg_index_t REG_INPUT_HIGH     = cfg_index_t'(1);
    localparam cfg_index_t REG_OUTPUT_AT_LOW  = cfg_index_t'(2);
    localparam cfg_index_t REG_OUTPUT_AT_HIGH = cfg_index_t'(3);

    // per-item flags carried down the pipeline
    typedef struct packed {
        logic bypass;   // clamped: result is the base value as it stands
        logic falling;  // output range falls: subtract quotient from base
    } map_flags_t;

endpackage

// ===== design/lrm_prep.sv =====
module lrm_prep #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [DATA_WIDTH-1:0]     sample,
    input  logic [DATA_WIDTH-1:0]     input_low,
    input  logic [DATA_WIDTH-1:0]     input_high,
    input  logic [DATA_WIDTH-1:0]     output_at_low,
    input  logic [DATA_WIDTH-1:0]     output_at_high,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*DATA_WIDTH-1:0]   num,
    output logic [DATA_WIDTH-1:0]     span,
    output logic [DATA_WIDTH-1:0]     base,
    output lrm_pkg::map_flags_t       flags
);

    localparam int W = DATA_WIDTH;

    // stage a: range check and spans
    logic                a_valid_reg;
    logic                a_ready;
    logic [W-1:0]        a_offset_reg;
    logic [W-1:0]        a_span_reg;
    logic [W-1:0]        a_ospan_reg;
    logic [W-1:0]        a_base_reg;
    lrm_pkg::map_flags_t a_flags_reg;

    // stage b: product
    logic                b_valid_reg;
    logic                b_ready;
    logic [2*W-1:0]      b_prod_reg;
    logic [W-1:0]        b_span_reg;
    logic [W-1:0]        b_base_reg;
    lrm_pkg::map_flags_t b_flags_reg;

    // stage c: rounded numerator
    logic                c_valid_reg;
    logic                c_ready;
    logic [2*W-1:0]      c_num_reg;
    logic [W-1:0]        c_span_reg;
    logic [W-1:0]        c_base_reg;
    lrm_pkg::map_flags_t c_flags_reg;

    logic                below;
    logic                above;
    lrm_pkg::map_flags_t a_flags_next;
    logic [W-1:0]        a_base_next;
    logic [W-1:0]        a_offset_next;
    logic [W-1:0]        a_ospan_next;

    // per-stage flow control
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // clamp decision and spans
    always_comb
    begin
        below                = sample < input_low;
        above                = sample >= input_high;
        a_flags_next.bypass  = below || above;
        a_flags_next.falling = output_at_high < output_at_low;
        if (!below && above)
        begin
            a_base_next = output_at_high;
        end
        else
        begin
            a_base_next = output_at_low;
        end
        a_offset_next = a_flags_next.bypass ? '0 : sample - input_low;
        a_ospan_next  = a_flags_next.falling ? output_at_low - output_at_high
                                             : output_at_high - output_at_low;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_offset_reg <= a_offset_next;
            a_span_reg   <= input_high - input_low;
            a_ospan_reg  <= a_ospan_next;
            a_base_reg   <= a_base_next;
            a_flags_reg  <= a_flags_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_prod_reg  <= {{W{1'b0}}, a_offset_reg} * {{W{1'b0}}, a_ospan_reg};
            b_span_reg  <= a_span_reg;
            b_base_reg  <= a_base_reg;
            b_flags_reg <= a_flags_reg;
        end
        if (b_valid_reg && c_ready)
        begin
            c_num_reg   <= b_prod_reg + {{(W+1){1'b0}}, b_span_reg[W-1:1]};
            c_span_reg  <= b_span_reg;
            c_base_reg  <= b_base_reg;
            c_flags_reg <= b_flags_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign num       = c_num_reg;
    assign span      = c_span_reg;
    assign base      = c_base_reg;
    assign flags     = c_flags_reg;

endmodule

// ===== design/lrm_div_cell.sv =====
module lrm_div_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_num,
    input  logic [DATA_WIDTH-1:0] in_quot,
    input  logic [DATA_WIDTH-1:0] in_span,
    input  logic [DATA_WIDTH-1:0] in_base,
    input  lrm_pkg::map_flags_t   in_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_num,
    output logic [DATA_WIDTH-1:0] out_quot,
    output logic [DATA_WIDTH-1:0] out_span,
    output logic [DATA_WIDTH-1:0] out_base,
    output lrm_pkg::map_flags_t   out_flags
);

    localparam int W = DATA_WIDTH;

    logic                valid_reg;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        num_reg;
    logic [W-1:0]        quot_reg;
    logic [W-1:0]        span_reg;
    logic [W-1:0]        base_reg;
    lrm_pkg::map_flags_t flags_reg;

    logic [W:0]          trial;
    logic [W:0]          diff;
    logic                take;
    logic [W-1:0]        rem_next;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    always_comb
    begin
        trial    = {in_rem, in_num[W-1]};
        diff     = trial - {1'b0, in_span};
        take     = !diff[W];
        rem_next = take ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg   <= rem_next;
            num_reg   <= {in_num[W-2:0], 1'b0};
            quot_reg  <= {in_quot[W-2:0], take};
            span_reg  <= in_span;
            base_reg  <= in_base;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quot  = quot_reg;
    assign out_span  = span_reg;
    assign out_base  = base_reg;
    assign out_flags = flags_reg;

endmodule

// ===== design/linear_range_map_rounded_u16_core.sv =====
// Linear range map with clamp and round-to-nearest. Each sample is mapped from the
// input range [input_low, input_high) onto output_at_low .. output_at_high (which may
// fall); samples below input_low give output_at_low, other samples at or above
// input_high give output_at_high. The block takes one item per clock while the
// result side does not stall, and passes it through stages of range check,
// multiply and rounding offset, a chain of DATA_WIDTH divider cells each settling
// one quotient bit, and an output register that applies the quotient to the base
// value. Every stage has its own valid bit, so bubbles close up and a stalled
// result only holds back the stages behind it. Registers are written through the
// cfg port (index 0 input_low, 1 input_high, 2 output_at_low, 3 output_at_high;
// other indexes are ignored), always ready, and must only be changed while no item
// is in flight. Reset gives the identity map.
module linear_range_map_rounded_u16_core #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [DATA_WIDTH-1:0]               sample,
    output logic                                mapped_valid,
    input  logic                                mapped_ready,
    output logic [DATA_WIDTH-1:0]               mapped
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] input_low_reg;
    logic [W-1:0] input_high_reg;
    logic [W-1:0] output_at_low_reg;
    logic [W-1:0] output_at_high_reg;

    logic         mapped_valid_reg;
    logic [W-1:0] mapped_reg;
    logic [W-1:0] mapped_next;
    logic         out_ready;

    logic [2*W-1:0] prep_num;

    // divider chain wiring, entry 0 is the chain input
    logic                chain_valid [0:W];
    logic                chain_ready [0:W];
    logic [W-1:0]        chain_rem   [0:W];
    logic [W-1:0]        chain_num   [0:W];
    logic [W-1:0]        chain_quot  [0:W];
    logic [W-1:0]        chain_span  [0:W];
    logic [W-1:0]        chain_base  [0:W];
    lrm_pkg::map_flags_t chain_flags [0:W];

    logic [W:0] sum_up;
    logic [W:0] sum_down;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_low_reg      <= '0;
            input_high_reg     <= '1;
            output_at_low_reg  <= '0;
            output_at_high_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lrm_pkg::REG_INPUT_LOW:      input_low_reg      <= cfg_data;
                lrm_pkg::REG_INPUT_HIGH:     input_high_reg     <= cfg_data;
                lrm_pkg::REG_OUTPUT_AT_LOW:  output_at_low_reg  <= cfg_data;
                lrm_pkg::REG_OUTPUT_AT_HIGH: output_at_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // range check, product and rounding offset
    lrm_prep #(
        .DATA_WIDTH (W)
    ) u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sample_valid),
        .in_ready       (sample_ready),
        .sample         (sample),
        .input_low      (input_low_reg),
        .input_high     (input_high_reg),
        .output_at_low  (output_at_low_reg),
        .output_at_high (output_at_high_reg),
        .out_valid      (chain_valid[0]),
        .out_ready      (chain_ready[0]),
        .num            (prep_num),
        .span           (chain_span[0]),
        .base           (chain_base[0]),
        .flags          (chain_flags[0])
    );

    assign chain_rem[0]  = prep_num[2*W-1:W];
    assign chain_num[0]  = prep_num[W-1:0];
    assign chain_quot[0] = '0;

    // divider: one cell per quotient bit, most significant first
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        lrm_div_cell #(
            .DATA_WIDTH (W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_rem    (chain_rem[i]),
            .in_num    (chain_num[i]),
            .in_quot   (chain_quot[i]),
            .in_span   (chain_span[i]),
            .in_base   (chain_base[i]),
            .in_flags  (chain_flags[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_num   (chain_num[i+1]),
            .out_quot  (chain_quot[i+1]),
            .out_span  (chain_span[i+1]),
            .out_base  (chain_base[i+1]),
            .out_flags (chain_flags[i+1])
        );
    end

    // apply quotient to the base value
    assign out_ready      = !mapped_valid_reg || mapped_ready;
    assign chain_ready[W] = out_ready;

    always_comb
    begin
        sum_up   = {1'b0, chain_base[W]} + {1'b0, chain_quot[W]};
        sum_down = {1'b0, chain_base[W]} - {1'b0, chain_quot[W]};
        if (chain_flags[W].bypass)
        begin
            mapped_next = chain_base[W];
        end
        else if (chain_flags[W].falling)
        begin
            mapped_next = sum_down[W-1:0];
        end
        else
        begin
            mapped_next = sum_up[W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            mapped_valid_reg <= chain_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[W] && out_ready)
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped_valid = mapped_valid_reg;
    assign mapped       = mapped_reg;

    // rising map never carries past the top of the output range
    a_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[W] && !chain_flags[W].bypass && !chain_flags[W].falling
        |-> !sum_up[W])
        else $error("rising map overflowed");

    // falling map never borrows below the bottom of the output range
    a_no_borrow: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[W] && !chain_flags[W].bypass && chain_flags[W].falling
        |-> !sum_down[W])
        else $error("falling map underflowed");

    // divider remainder stays below the divisor at the chain input
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] && !chain_flags[0].bypass
        |-> chain_rem[0] < chain_span[0])
        else $error("quotient would not fit the output width");

    // an empty output register never holds back the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !mapped_valid_reg |-> sample_ready)
        else $error("pipeline stalled with no result waiting");

endmodule

// ===== tb/tb_linear_range_map_rounded_u16_core.sv =====
`timescale 1ns / 100ps

module tb_linear_range_map_rounded_u16_core;

    localparam int          DATA_WIDTH   = 16;
    localparam int          IDLE_PCT     = 29;
    localparam int          RANDOM_ITEMS = 720;
    localparam int          SETTLE_LEN   = 30;
    localparam int          QUIET_LIMIT  = 2000;
    localparam lrm_pkg::cfg_index_t REG_INDEX_MAX = {lrm_pkg::CFG_INDEX_WIDTH{1'b1}};

    typedef logic [DATA_WIDTH-1:0] word_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    lrm_pkg::cfg_index_t cfg_index = '0;
    word_t       cfg_data     = '0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    word_t       sample       = '0;
    logic        mapped_valid;
    logic        mapped_ready = 1'b0;
    word_t       mapped;

    // own copy of the mapping registers, reset gives the identity map
    word_t map_in_low   = '0;
    word_t map_in_high  = '1;
    word_t map_out_low  = '0;
    word_t map_out_high = '1;

    word_t       expected_mapped[$];
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;
    bit          steady      = 1'b0;

    linear_range_map_rounded_u16_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .mapped_valid(mapped_valid),
        .mapped_ready(mapped_ready),
        .mapped      (mapped)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // clamp, then base value plus or minus the rounded quotient
    function automatic word_t map_sample(input word_t value);
        logic [63:0] span;
        logic [63:0] offset;
        logic [63:0] ospan;
        logic [63:0] quot;
        bit          falling;
        if (value < map_in_low)
            return map_out_low;
        if (value >= map_in_high)
            return map_out_high;
        falling = map_out_high < map_out_low;
        span    = 64'(map_in_high) - 64'(map_in_low);
        offset  = 64'(value) - 64'(map_in_low);
        ospan   = falling ? 64'(map_out_low) - 64'(map_out_high)
                          : 64'(map_out_high) - 64'(map_out_low);
        quot    = (offset * ospan + (span >> 1)) / span;
        return falling ? word_t'(map_out_low - quot[DATA_WIDTH-1:0])
                       : word_t'(map_out_low + quot[DATA_WIDTH-1:0]);
    endfunction

    // result checking and random stalls on the result side
    always @(posedge clk)
    begin
        if (rst_n && mapped_valid && mapped_ready)
        begin
            if (expected_mapped.size() == 0)
            begin
                $error("mapped: unexpected item, actual %0d", mapped);
                mismatches++;
            end
            else
            begin
                word_t want;
                want = expected_mapped.pop_front();
                if (mapped !== want)
                begin
                    $error("mapped: expected %0d, actual %0d", want, mapped);
                    mismatches++;
                end
            end
        end
        mapped_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (mapped_valid && mapped_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one sample item, with a random gap in front of it
    task automatic send_sample(input word_t value);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        expected_mapped.push_back(map_sample(value));
    endtask

    // sender holds off until every result is back
    task automatic wait_for_results();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_mapped.size() != 0);
    endtask

    // one register write, valid is left high for back-to-back writes
    task automatic write_reg(input lrm_pkg::cfg_index_t idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lrm_pkg::REG_INPUT_LOW:      map_in_low   = value;
            lrm_pkg::REG_INPUT_HIGH:     map_in_high  = value;
            lrm_pkg::REG_OUTPUT_AT_LOW:  map_out_low  = value;
            lrm_pkg::REG_OUTPUT_AT_HIGH: map_out_high = value;
            default: ;
        endcase
    endtask

    task automatic apply_map(input word_t in_low, input word_t in_high,
                             input word_t out_low, input word_t out_high);
        wait_for_results();
        write_reg(lrm_pkg::REG_INPUT_LOW, in_low);
        write_reg(lrm_pkg::REG_INPUT_HIGH, in_high);
        write_reg(lrm_pkg::REG_OUTPUT_AT_LOW, out_low);
        write_reg(lrm_pkg::REG_OUTPUT_AT_HIGH, out_high);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // identity map straight out of reset
    task automatic test_reset_map();
        send_sample('0);
        send_sample(word_t'(1));
        send_sample(word_t'(32768));
        send_sample(word_t'(65534));
        send_sample('1);
    endtask

    // rising output range, both clamps and the bound edges
    task automatic test_rising_range();
        apply_map(word_t'(1000), word_t'(5000), word_t'(200), word_t'(60000));
        send_sample(word_t'(999));
        send_sample(word_t'(1000));
        send_sample(word_t'(1001));
        send_sample(word_t'(2999));
        send_sample(word_t'(4999));
        send_sample(word_t'(5000));
    endtask

    // falling output range over the full input span
    task automatic test_falling_range();
        apply_map('0, '1, '1, '0);
        send_sample('0);
        send_sample(word_t'(32767));
        send_sample(word_t'(65534));
        send_sample('1);
    endtask

    // empty and inverted input ranges, equal output ends
    task automatic test_degenerate_ranges();
        apply_map(word_t'(500), word_t'(500), word_t'(100), word_t'(9000));
        send_sample(word_t'(499));
        send_sample(word_t'(500));
        apply_map(word_t'(60000), word_t'(100), word_t'(7), word_t'(65000));
        send_sample(word_t'(99));
        send_sample(word_t'(100));
        send_sample(word_t'(60000));
        apply_map('0, word_t'(1000), word_t'(4242), word_t'(4242));
        send_sample(word_t'(1));
        send_sample(word_t'(999));
    endtask

    // writes to unused indexes leave the map alone
    task automatic test_unknown_index();
        wait_for_results();
        write_reg(REG_INDEX_MAX, word_t'(12345));
        write_reg(lrm_pkg::cfg_index_t'($urandom_range(lrm_pkg::REG_OUTPUT_AT_HIGH + 1,
                                                        REG_INDEX_MAX)),
                  word_t'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_sample(word_t'(500));
    endtask

    function automatic word_t pick_bound();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return word_t'($urandom);
        endcase
    endfunction

    // mostly inside the input range, some at its edges, some anywhere
    function automatic word_t pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (map_in_low < map_in_high && roll < 65)
            return word_t'($urandom_range(map_in_high, map_in_low));
        if (roll < 85)
        begin
            case ($urandom_range(3))
                0:       return map_in_low - 1'b1;
                1:       return map_in_low;
                2:       return map_in_high - 1'b1;
                default: return map_in_high;
            endcase
        end
        return word_t'($urandom);
    endfunction

    // random maps in phases, sender paused before each reconfiguration
    task automatic test_random_maps();
        int unsigned sent;
        int unsigned phase;
        int unsigned burst;
        word_t       lo;
        word_t       hi;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            lo = pick_bound();
            hi = pick_bound();
            if ($urandom_range(9) < 3)
                hi = lo + word_t'($urandom_range(1, 8));
            else if ($urandom_range(9) < 8 && hi < lo)
            begin
                hi = lo;
                lo = pick_bound();
            end
            apply_map(lo, hi, pick_bound(), pick_bound());
            steady = (phase == 3);
            burst  = $urandom_range(20, 80);
            for (int unsigned i = 0; i < burst; i++)
                send_sample(pick_sample());
            sent  += burst;
            phase++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_map();
        test_rising_range();
        test_falling_range();
        test_degenerate_ranges();
        test_unknown_index();
        test_random_maps();
        wait_for_results();
        repeat (SETTLE_LEN)
            @(posedge clk);
        mismatches += expected_mapped.size();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
